// File: rtl/core/ppl_pkg.sv
`default_nettype none
package ppl_pkg;

   localparam int POOL_SLOTS = 16;
   localparam int SLOT_BYTES = 512;

   localparam int SLOT_W  = $clog2(POOL_SLOTS);
   localparam int LINK_W  = $clog2(POOL_SLOTS + 1);
   localparam int LEN_W   = $clog2(SLOT_BYTES + 1);
   localparam int BYTE_DEPTH = POOL_SLOTS * SLOT_BYTES;
   localparam int BYTE_AW = $clog2(BYTE_DEPTH);

   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [BYTE_AW-1:0] baddr_type;
   typedef logic [SLOT_W-1:0]  ram_addr_type;

   typedef logic [2:0] action_type;
   typedef logic [1:0] status_type;
   typedef logic [3:0] slot_idx_type;
   typedef logic [9:0] pkt_len_type;

   localparam link_type NULL_SLOT = link_type'(POOL_SLOTS);

   localparam action_type ACT_PUSH    = 3'd0;
   localparam action_type ACT_CLEAR   = 3'd1;
   localparam action_type ACT_RESTART = 3'd2;
   localparam action_type ACT_NEXT    = 3'd3;
   localparam action_type ACT_READ    = 3'd4;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_TRUNC = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

   function automatic logic slot_ok(input link_type s);
      return s < NULL_SLOT;
   endfunction

   function automatic baddr_type byte_addr(input baddr_type slot, input baddr_type off);
      return baddr_type'(slot * baddr_type'(SLOT_BYTES)) + off;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ppl_ram.sv
`default_nettype none
module ppl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/core/packet_pool_lifo_list.sv
`default_nettype none
// Channel   Ports                                   Transfer
// request   start, busy, req_*                      start high and busy low at a clock edge
// response  rsp_strobe, rsp_*                       one cycle per transaction, no back pressure
//
// After reset the block initializes the link and length memory entries of every slot in turn,
// with busy high. A push into an open slot or during a drop, a push that finds the pool full,
// a restart, an empty next and an unused action finish in idle; a push that opens a slot,
// a next that returns a slot and a read wait in a state of their own for the memory read.
// A clear steps through S_CLR_RD and S_CLR_WR per slot on the list, since each link is read
// and then written back. The response follows in the next cycle; the receiver cannot stall it.
module packet_pool_lifo_list (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [2:0]            req_action,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_last_byte,
   input  wire logic [3:0]            req_read_slot,
   input  wire logic [8:0]            req_read_offset,
   output      logic                  rsp_strobe,
   output      logic [1:0]            rsp_status,
   output      logic                  rsp_slot_valid,
   output      logic [3:0]            rsp_slot_index,
   output      logic [9:0]            rsp_slot_len,
   output      logic [7:0]            rsp_byte_out
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC,
      S_NEXT,
      S_READ,
      S_CLR_RD,
      S_CLR_WR
   } state_type;

   state_type state_ff, state_in;

   ppl_pkg::link_type init_idx_ff, init_idx_in;
   ppl_pkg::link_type free_front_ff, free_front_in;
   ppl_pkg::link_type list_front_ff, list_front_in;
   ppl_pkg::link_type iter_origin_ff, iter_origin_in;
   ppl_pkg::link_type iter_cursor_ff, iter_cursor_in;
   ppl_pkg::link_type fill_slot_ff, fill_slot_in;
   ppl_pkg::len_type  fill_count_ff, fill_count_in;
   logic              drop_ff, drop_in;
   logic              trunc_ff, trunc_in;
   ppl_pkg::link_type node_ff, node_in;
   ppl_pkg::link_type guard_ff, guard_in;
   ppl_pkg::link_type op_slot_ff, op_slot_in;
   logic              op_last_ff, op_last_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   ppl_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic                   rsp_slot_valid_ff, rsp_slot_valid_in;
   ppl_pkg::slot_idx_type  rsp_slot_index_ff, rsp_slot_index_in;
   ppl_pkg::pkt_len_type   rsp_slot_len_ff, rsp_slot_len_in;
   logic [7:0]             rsp_byte_out_ff, rsp_byte_out_in;

   logic                       link_we;
   ppl_pkg::ram_addr_type      link_wa, link_ra;
   ppl_pkg::link_type          link_wd, link_rd;
   logic                       len_we;
   ppl_pkg::ram_addr_type      len_wa, len_ra;
   ppl_pkg::len_type           len_wd, len_rd;
   logic                       byte_we;
   ppl_pkg::baddr_type         byte_wa, byte_ra;
   logic [7:0]                 byte_rd;

   logic                       accept;
   ppl_pkg::link_type          next_sel;
   ppl_pkg::len_type           count_new;
   logic                       trunc_new;

   ppl_ram #(.WIDTH(ppl_pkg::LINK_W), .DEPTH(ppl_pkg::POOL_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   ppl_ram #(.WIDTH(ppl_pkg::LEN_W), .DEPTH(ppl_pkg::POOL_SLOTS)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_wa),
      .wr_data (len_wd),
      .rd_addr (len_ra),
      .rd_data (len_rd)
   );

   ppl_ram #(.WIDTH(8), .DEPTH(ppl_pkg::BYTE_DEPTH)) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we),
      .wr_addr (byte_wa),
      .wr_data (req_data_byte),
      .rd_addr (byte_ra),
      .rd_data (byte_rd)
   );

   assign busy              = (state_ff != S_IDLE);
   assign accept            = start && !busy;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_valid    = rsp_slot_valid_ff;
   assign rsp_slot_index    = rsp_slot_index_ff;
   assign rsp_slot_len      = rsp_slot_len_ff;
   assign rsp_byte_out      = rsp_byte_out_ff;

   always_comb begin
      state_in       = state_ff;
      init_idx_in    = init_idx_ff;
      free_front_in  = free_front_ff;
      list_front_in  = list_front_ff;
      iter_origin_in = iter_origin_ff;
      iter_cursor_in = iter_cursor_ff;
      fill_slot_in   = fill_slot_ff;
      fill_count_in  = fill_count_ff;
      drop_in        = drop_ff;
      trunc_in       = trunc_ff;
      node_in        = node_ff;
      guard_in       = guard_ff;
      op_slot_in     = op_slot_ff;
      op_last_in     = op_last_ff;

      rsp_strobe_in        = 1'b0;
      rsp_status_in        = ppl_pkg::ST_OK;
      rsp_slot_valid_in    = 1'b0;
      rsp_slot_index_in    = '0;
      rsp_slot_len_in      = '0;
      rsp_byte_out_in      = '0;

      link_we = 1'b0;
      link_wa = '0;
      link_wd = '0;
      link_ra = '0;
      len_we  = 1'b0;
      len_wa  = '0;
      len_wd  = '0;
      len_ra  = '0;
      byte_we = 1'b0;
      byte_wa = ppl_pkg::byte_addr(ppl_pkg::baddr_type'(fill_slot_ff),
                                   ppl_pkg::baddr_type'(fill_count_ff));
      byte_ra = ppl_pkg::byte_addr(ppl_pkg::baddr_type'(req_read_slot),
                                   ppl_pkg::baddr_type'(req_read_offset));

      next_sel  = ppl_pkg::slot_ok(iter_cursor_ff) ? iter_cursor_ff : iter_origin_ff;
      count_new = fill_count_ff;
      trunc_new = trunc_ff;

      case (state_ff)
         S_INIT: begin
            link_we = 1'b1;
            link_wa = init_idx_ff[ppl_pkg::SLOT_W-1:0];
            link_wd = init_idx_ff + 1'b1;
            len_we  = 1'b1;
            len_wa  = init_idx_ff[ppl_pkg::SLOT_W-1:0];
            len_wd  = '0;
            init_idx_in = init_idx_ff + 1'b1;
            if (init_idx_ff == ppl_pkg::link_type'(ppl_pkg::POOL_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               case (req_action)
                  ppl_pkg::ACT_PUSH: begin
                     if (drop_ff) begin
                        rsp_status_in = ppl_pkg::ST_FULL;
                        if (req_last_byte) begin
                           drop_in = 1'b0;
                        end
                     end else if (ppl_pkg::slot_ok(fill_slot_ff)) begin
                        if (fill_count_ff < ppl_pkg::len_type'(ppl_pkg::SLOT_BYTES)) begin
                           byte_we   = 1'b1;
                           count_new = fill_count_ff + 1'b1;
                        end else begin
                           trunc_new     = 1'b1;
                           rsp_status_in = ppl_pkg::ST_TRUNC;
                        end
                        fill_count_in = count_new;
                        trunc_in      = trunc_new;
                        if (req_last_byte) begin
                           len_we  = 1'b1;
                           len_wa  = fill_slot_ff[ppl_pkg::SLOT_W-1:0];
                           len_wd  = count_new;
                           link_we = 1'b1;
                           link_wa = fill_slot_ff[ppl_pkg::SLOT_W-1:0];
                           link_wd = list_front_ff;
                           list_front_in = fill_slot_ff;
                           if (trunc_new) begin
                              rsp_status_in = ppl_pkg::ST_TRUNC;
                           end
                           fill_slot_in  = ppl_pkg::NULL_SLOT;
                           fill_count_in = '0;
                           trunc_in      = 1'b0;
                        end
                     end else if (!ppl_pkg::slot_ok(free_front_ff)) begin
                        rsp_status_in = ppl_pkg::ST_FULL;
                        drop_in       = !req_last_byte;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        byte_we = 1'b1;
                        byte_wa = ppl_pkg::byte_addr(ppl_pkg::baddr_type'(free_front_ff), '0);
                        link_ra = free_front_ff[ppl_pkg::SLOT_W-1:0];
                        op_slot_in = free_front_ff;
                        op_last_in = req_last_byte;
                        state_in   = S_ALLOC;
                     end
                  end
                  ppl_pkg::ACT_CLEAR: begin
                     rsp_strobe_in = 1'b0;
                     node_in  = list_front_ff;
                     guard_in = '0;
                     state_in = S_CLR_RD;
                  end
                  ppl_pkg::ACT_RESTART: begin
                     iter_origin_in = list_front_ff;
                     iter_cursor_in = list_front_ff;
                  end
                  ppl_pkg::ACT_NEXT: begin
                     iter_cursor_in = next_sel;
                     if (ppl_pkg::slot_ok(next_sel)) begin
                        rsp_strobe_in = 1'b0;
                        link_ra    = next_sel[ppl_pkg::SLOT_W-1:0];
                        len_ra     = next_sel[ppl_pkg::SLOT_W-1:0];
                        op_slot_in = next_sel;
                        state_in   = S_NEXT;
                     end else begin
                        rsp_status_in = ppl_pkg::ST_EMPTY;
                     end
                  end
                  ppl_pkg::ACT_READ: begin
                     if (32'(req_read_slot) < ppl_pkg::POOL_SLOTS
                         && 32'(req_read_offset) < ppl_pkg::SLOT_BYTES) begin
                        rsp_strobe_in = 1'b0;
                        state_in      = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ALLOC: begin
            rsp_strobe_in = 1'b1;
            free_front_in = link_rd;
            link_we = 1'b1;
            link_wa = op_slot_ff[ppl_pkg::SLOT_W-1:0];
            trunc_in = 1'b0;
            if (op_last_ff) begin
               link_wd = list_front_ff;
               len_we  = 1'b1;
               len_wa  = op_slot_ff[ppl_pkg::SLOT_W-1:0];
               len_wd  = ppl_pkg::len_type'(1);
               list_front_in = op_slot_ff;
               fill_slot_in  = ppl_pkg::NULL_SLOT;
               fill_count_in = '0;
            end else begin
               link_wd = ppl_pkg::NULL_SLOT;
               fill_slot_in  = op_slot_ff;
               fill_count_in = ppl_pkg::len_type'(1);
            end
            state_in = S_IDLE;
         end
         S_NEXT: begin
            rsp_strobe_in        = 1'b1;
            rsp_slot_valid_in    = 1'b1;
            rsp_slot_index_in    = ppl_pkg::slot_idx_type'(op_slot_ff);
            rsp_slot_len_in      = ppl_pkg::pkt_len_type'(len_rd);
            iter_cursor_in       = link_rd;
            state_in             = S_IDLE;
         end
         S_READ: begin
            rsp_strobe_in   = 1'b1;
            rsp_byte_out_in = byte_rd;
            state_in        = S_IDLE;
         end
         S_CLR_RD: begin
            if (ppl_pkg::slot_ok(node_ff)
                && guard_ff < ppl_pkg::link_type'(ppl_pkg::POOL_SLOTS)) begin
               link_ra  = node_ff[ppl_pkg::SLOT_W-1:0];
               state_in = S_CLR_WR;
            end else begin
               list_front_in  = ppl_pkg::NULL_SLOT;
               iter_origin_in = ppl_pkg::NULL_SLOT;
               iter_cursor_in = ppl_pkg::NULL_SLOT;
               rsp_strobe_in  = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CLR_WR: begin
            link_we = 1'b1;
            link_wa = node_ff[ppl_pkg::SLOT_W-1:0];
            link_wd = free_front_ff;
            free_front_in = node_ff;
            node_in  = link_rd;
            guard_in = guard_ff + 1'b1;
            state_in = S_CLR_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         init_idx_ff    <= '0;
         free_front_ff  <= '0;
         list_front_ff  <= ppl_pkg::NULL_SLOT;
         iter_origin_ff <= ppl_pkg::NULL_SLOT;
         iter_cursor_ff <= ppl_pkg::NULL_SLOT;
         fill_slot_ff   <= ppl_pkg::NULL_SLOT;
         fill_count_ff  <= '0;
         drop_ff        <= 1'b0;
         trunc_ff       <= 1'b0;
         node_ff        <= ppl_pkg::NULL_SLOT;
         guard_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_idx_ff    <= init_idx_in;
         free_front_ff  <= free_front_in;
         list_front_ff  <= list_front_in;
         iter_origin_ff <= iter_origin_in;
         iter_cursor_ff <= iter_cursor_in;
         fill_slot_ff   <= fill_slot_in;
         fill_count_ff  <= fill_count_in;
         drop_ff        <= drop_in;
         trunc_ff       <= trunc_in;
         node_ff        <= node_in;
         guard_ff       <= guard_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      op_slot_ff           <= op_slot_in;
      op_last_ff           <= op_last_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_slot_valid_ff    <= rsp_slot_valid_in;
      rsp_slot_index_ff    <= rsp_slot_index_in;
      rsp_slot_len_ff      <= rsp_slot_len_in;
      rsp_byte_out_ff      <= rsp_byte_out_in;
   end

endmodule
`default_nettype wire
